>>> rtl/core/mrfc_pkg.sv
// mrfc_pkg: shared types, constants and the crc-16 byte update for the
// modbus rtu frame checker. no dependencies.
package mrfc_pkg;

  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [7:0]  FUNC_READ     = 8'h03;
  localparam logic [7:0]  FUNC_WRITE    = 8'h06;
  localparam logic [7:0]  MIN_LENGTH    = 8'd6;
  localparam logic [7:0]  COUNT_MAX     = 8'd255;
  localparam logic [7:0]  ADDRESS_RESET = 8'h10;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_ADDRESS   = 3'd1;
  localparam logic [2:0] STATUS_CRC       = 3'd2;
  localparam logic [2:0] STATUS_FUNCTION  = 3'd3;
  localparam logic [2:0] STATUS_SHORT     = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  function_code;
    logic [7:0]  frame_length;
    logic [15:0] threshold_value;
  } out_res_t;

  // one byte of reflected crc, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) crc = (crc >> 1) ^ CRC_POLY;
      else        crc = crc >> 1;
    end
    return crc;
  endfunction

endpackage

>>> rtl/core/modbus_rtu_frame_checker_top.sv
// modbus_rtu_frame_checker_top: byte-wide modbus rtu request checker with
// running crc, field capture and a registered result. depends on mrfc_pkg.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------
//  in       | input     | in_valid/in_stall  | mrfc_pkg::in_req_t
//  out      | output    | out_valid/out_stall| mrfc_pkg::out_res_t
//  cfg      | input     | cfg_write          | cfg_data (own address)
//
// one byte is taken per unstalled cycle; the crc byte update and the checks
// settle in the accept cycle and the result register loads in the cycle
// after the final byte. reset is synchronous and returns the address to 0x10.
// a held result stalls the input only while out_stall keeps it in place.
module modbus_rtu_frame_checker_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mrfc_pkg::in_req_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mrfc_pkg::out_res_t  out_data,
  input  logic                cfg_write,
  input  logic [7:0]          cfg_data
);

  logic [7:0]  own_address;
  logic [15:0] crc_acc;
  logic [7:0]  byte_count;
  logic [7:0]  delay0, delay1;
  logic [7:0]  address_byte, function_byte, value_low, value_high;
  logic [15:0] threshold;

  logic        accept;
  logic [15:0] crc_next;
  logic [7:0]  count_next;
  logic [7:0]  address_next, function_next, low_next, high_next;
  logic [15:0] threshold_next;
  logic [15:0] rx_crc;
  logic [2:0]  status_next;
  logic        write_hit;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    crc_next      = (byte_count >= 8'd2) ? mrfc_pkg::crc_byte(crc_acc, delay1) : crc_acc;
    count_next    = (byte_count < mrfc_pkg::COUNT_MAX) ? byte_count + 8'd1 : byte_count;
    address_next  = (byte_count == 8'd0) ? in_data.data_byte : address_byte;
    function_next = (byte_count == 8'd1) ? in_data.data_byte : function_byte;
    low_next      = (byte_count == 8'd4) ? in_data.data_byte : value_low;
    high_next     = (byte_count == 8'd5) ? in_data.data_byte : value_high;
    // received crc: low byte came first, so it sits one byte back
    rx_crc        = {in_data.data_byte, delay0};
    write_hit     = 1'b0;
    if (count_next <= mrfc_pkg::MIN_LENGTH)     status_next = mrfc_pkg::STATUS_SHORT;
    else if (rx_crc != crc_next)                status_next = mrfc_pkg::STATUS_CRC;
    else if (address_next != own_address)       status_next = mrfc_pkg::STATUS_ADDRESS;
    else if (function_next == mrfc_pkg::FUNC_READ) status_next = mrfc_pkg::STATUS_OK;
    else if (function_next == mrfc_pkg::FUNC_WRITE) begin
      status_next = mrfc_pkg::STATUS_OK;
      write_hit   = 1'b1;
    end else                                    status_next = mrfc_pkg::STATUS_FUNCTION;
    threshold_next = write_hit ? {high_next, low_next} : threshold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address   <= mrfc_pkg::ADDRESS_RESET;
      crc_acc       <= mrfc_pkg::CRC_INIT;
      byte_count    <= '0;
      delay0        <= '0;
      delay1        <= '0;
      address_byte  <= '0;
      function_byte <= '0;
      value_low     <= '0;
      value_high    <= '0;
      threshold     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) own_address <= cfg_data;
      if (accept && in_data.last_byte) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (accept) begin
        if (in_data.last_byte) begin
          crc_acc       <= mrfc_pkg::CRC_INIT;
          byte_count    <= '0;
          delay0        <= '0;
          delay1        <= '0;
          address_byte  <= '0;
          function_byte <= '0;
          value_low     <= '0;
          value_high    <= '0;
          threshold     <= threshold_next;
        end else begin
          crc_acc       <= crc_next;
          byte_count    <= count_next;
          delay0        <= in_data.data_byte;
          delay1        <= delay0;
          address_byte  <= address_next;
          function_byte <= function_next;
          value_low     <= low_next;
          value_high    <= high_next;
        end
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept && in_data.last_byte) begin
      out_data.status          <= status_next;
      out_data.function_code   <= function_next;
      out_data.frame_length    <= count_next;
      out_data.threshold_value <= threshold_next;
    end
  end

endmodule

>>> rtl/core/mrfc_checker.sv
// mrfc_checker: port-level assertions for modbus_rtu_frame_checker_top,
// attached by bind at the end of this file. depends on mrfc_pkg.
module mrfc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input mrfc_pkg::in_req_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input mrfc_pkg::out_res_t out_data
);

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a final byte request always yields a result next cycle
  a_final: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.last_byte |=> out_valid)
    else $error("final byte gave no result");

  // a middle byte with a free result slot yields nothing
  a_middle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !in_data.last_byte && !(out_valid && out_stall)
    |=> !out_valid)
    else $error("result without final byte");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= mrfc_pkg::STATUS_SHORT)
    else $error("status code out of range");

endmodule

bind modbus_rtu_frame_checker_top mrfc_checker u_mrfc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> tb/sv/frame_verdict_pkg.sv
`timescale 1ns / 100ps
// frame_verdict_pkg: crc-16/modbus helper and the scoreboard class that tracks
// modbus rtu requests byte by byte and queues the verdicts they should produce.
// depends on mrfc_pkg for the payload types, status codes and function codes.
package frame_verdict_pkg;
  import mrfc_pkg::*;

  // bitwise form of the reflected crc, one data bit per step
  function automatic logic [15:0] crc16_update(input logic [15:0] acc,
                                               input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = acc[0] ^ b[i];
      acc = acc >> 1;
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  class frame_verdicts;
    logic [7:0]  station;
    logic [15:0] crc_run;
    logic [7:0]  count;
    logic [7:0]  lag0;
    logic [7:0]  lag1;
    logic [7:0]  addr_b;
    logic [7:0]  func_b;
    logic [7:0]  val_lo;
    logic [7:0]  val_hi;
    logic [15:0] threshold;
    out_res_t    due[$];
    int          errors;

    function new();
      station = ADDRESS_RESET;
      threshold = '0;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      crc_run = CRC_INIT;
      count = '0;
      lag0 = '0;
      lag1 = '0;
      addr_b = '0;
      func_b = '0;
      val_lo = '0;
      val_hi = '0;
    endfunction

    // one accepted request byte; a final byte queues the expected verdict
    function void take_byte(input in_req_t req);
      logic [7:0]  pos;
      logic [15:0] rx_crc;
      logic [2:0]  st;
      out_res_t    res;
      pos = count;
      // the crc covers a byte only once two more have arrived
      if (pos >= 8'd2) crc_run = crc16_update(crc_run, lag1);
      lag1 = lag0;
      lag0 = req.data_byte;
      case (pos)
        8'd0: addr_b = req.data_byte;
        8'd1: func_b = req.data_byte;
        8'd4: val_lo = req.data_byte;
        8'd5: val_hi = req.data_byte;
        default: ;
      endcase
      if (count != COUNT_MAX) count = count + 8'd1;
      if (!req.last_byte) return;
      rx_crc = {lag0, lag1};
      if (count <= MIN_LENGTH) st = STATUS_SHORT;
      else if (rx_crc != crc_run) st = STATUS_CRC;
      else if (addr_b != station) st = STATUS_ADDRESS;
      else if (func_b == FUNC_READ) st = STATUS_OK;
      else if (func_b == FUNC_WRITE) begin
        st = STATUS_OK;
        threshold = {val_hi, val_lo};
      end else st = STATUS_FUNCTION;
      res.status = st;
      res.function_code = func_b;
      res.frame_length = count;
      res.threshold_value = threshold;
      due.push_back(res);
      clear_frame();
    endfunction

    task flag_mismatch(input string what, input logic [15:0] got, input logic [15:0] want);
      if (errors < 40) $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
    endtask

    task match_verdict(input out_res_t got);
      out_res_t want;
      if (due.size() == 0) begin
        flag_mismatch("unexpected verdict", 16'(got.status), '0);
        return;
      end
      want = due.pop_front();
      if (got.status !== want.status)
        flag_mismatch("status", 16'(got.status), 16'(want.status));
      if (got.function_code !== want.function_code)
        flag_mismatch("function_code", 16'(got.function_code), 16'(want.function_code));
      if (got.frame_length !== want.frame_length)
        flag_mismatch("frame_length", 16'(got.frame_length), 16'(want.frame_length));
      if (got.threshold_value !== want.threshold_value)
        flag_mismatch("threshold_value", got.threshold_value, want.threshold_value);
    endtask
  endclass

endpackage

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// tb_top: drives modbus rtu requests into modbus_rtu_frame_checker_top with random
// gaps and stalls and checks every verdict. depends on mrfc_pkg and frame_verdict_pkg.
module tb_top;
  import mrfc_pkg::*;
  import frame_verdict_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_BYTES  = 130;

  logic     clk = 1'b0;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_data;
  logic     cfg_write;
  logic [7:0] cfg_data;

  logic       steady;
  int         hold_count;
  int         hold_seen;
  int         hold_left;
  int         bytes_sent;
  logic [7:0] station;
  logic [7:0] frame_bytes[$];
  frame_verdicts verdicts;

  modbus_rtu_frame_checker_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_count) begin
      hold_seen <= hold_count;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 24);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) verdicts.match_verdict(out_data);
      if (in_valid && !in_stall) verdicts.take_byte(in_data);
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("FAIL modbus_rtu_frame_checker_top");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    if (!steady) while ($urandom_range(99) < 24) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {b, last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // append the crc of the frame so far, low byte first, spoiled by flip
  task automatic add_crc(input logic [15:0] flip);
    logic [15:0] acc;
    acc = CRC_INIT;
    foreach (frame_bytes[i]) acc = crc16_update(acc, frame_bytes[i]);
    acc = acc ^ flip;
    frame_bytes.push_back(acc[7:0]);
    frame_bytes.push_back(acc[15:8]);
  endtask

  // one edge first so the final byte is already in the scoreboard
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_address(input logic [7:0] a);
    cfg_write <= 1'b1;
    cfg_data <= a;
    @(posedge clk);
    cfg_write <= 1'b0;
    station = a;
    verdicts.station = a;
  endtask

  task automatic random_frame();
    int pick;
    int body_len;
    logic [7:0] head;
    logic [15:0] flip;
    pick = $urandom_range(99);
    frame_bytes = {};
    flip = '0;
    if (pick < 20) begin
      // short frames and noise, crc left to chance
      body_len = (pick < 10) ? $urandom_range(1, 6) : $urandom_range(7, 20);
      repeat (body_len) frame_bytes.push_back(8'($urandom));
    end else begin
      body_len = $urandom_range(5, 14);
      head = station;
      if (pick >= 75 && pick < 87) begin
        // foreign address, broadcast now and then
        if (station != 8'h00 && $urandom_range(2) == 0) head = 8'h00;
        else while (head == station) head = 8'($urandom);
      end
      frame_bytes.push_back(head);
      if (pick >= 65 && pick < 75) frame_bytes.push_back(8'($urandom));
      else frame_bytes.push_back($urandom_range(1) ? FUNC_WRITE : FUNC_READ);
      repeat (body_len - 2) frame_bytes.push_back(8'($urandom));
      if (pick >= 87) flip = 16'($urandom_range(1, 65535));
      add_crc(flip);
    end
    send_frame();
  endtask

  initial begin
    int target;
    logic [7:0] phase_addr[5];
    logic paused;
    verdicts = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_data = '0;
    steady = 1'b0;
    hold_count = 0;
    bytes_sent = 0;
    station = ADDRESS_RESET;
    paused = 1'b0;
    phase_addr[0] = 8'hFF;
    phase_addr[1] = 8'h00;
    phase_addr[2] = 8'($urandom);
    phase_addr[3] = ADDRESS_RESET;
    phase_addr[4] = 8'($urandom);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed requests at the reset address: lone byte, six-byte frame,
    // write of the largest threshold, plain read
    frame_bytes = {8'hFF};
    send_frame();
    frame_bytes = {8'h10, 8'h06, 8'h00, 8'hFF, 8'h12, 8'h34};
    send_frame();
    frame_bytes = {8'h10, 8'h06, 8'h00, 8'h01, 8'hFF, 8'hFF};
    add_crc('0);
    send_frame();
    frame_bytes = {8'h10, 8'h03, 8'h00, 8'h00, 8'h00};
    add_crc('0);
    send_frame();

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      write_address(phase_addr[ph]);
      if (ph == 1) steady <= 1'b1;
      if (ph == 2) begin
        steady <= 1'b0;
        // receiver holds off while requests keep coming
        hold_count <= hold_count + 1;
      end
      if (ph == 0) begin
        // over 255 bytes, the count has to saturate
        frame_bytes = {};
        frame_bytes.push_back(station);
        frame_bytes.push_back(FUNC_WRITE);
        repeat ($urandom_range(252, 296)) frame_bytes.push_back(8'($urandom));
        add_crc('0);
        send_frame();
      end
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        random_frame();
        if (ph == 3 && !paused && bytes_sent > target - PHASE_BYTES / 2) begin
          settle();
          paused = 1'b1;
        end
      end
    end

    settle();
    repeat (6) @(posedge clk);
    if (verdicts.errors == 0) $display("PASS modbus_rtu_frame_checker_top");
    else $display("FAIL modbus_rtu_frame_checker_top");
    $finish;
  end

endmodule

>>> files.f
rtl/core/mrfc_pkg.sv
rtl/core/modbus_rtu_frame_checker_top.sv
rtl/core/mrfc_checker.sv
tb/sv/frame_verdict_pkg.sv
tb/sv/tb_top.sv
